// File: design/ordered_multiset_table_core_macros.svh
`ifndef ORDERED_MULTISET_TABLE_CORE_MACROS_SVH
`define ORDERED_MULTISET_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/omt_pkg.sv
package omt_pkg;

    // Default number of table slots.
    localparam int OMT_DEFAULT_DEPTH = 64;

    // Command codes.
    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_COUNT     = 3'd2;
    localparam logic [2:0] CMD_ERASE_ONE = 3'd3;
    localparam logic [2:0] CMD_ERASE_ALL = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_RANGE     = 2'd3;

endpackage

// File: design/ordered_multiset_table_core.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------
// command   | in        | start high, busy low| i_cmd, i_value, i_index
// result    | out       | o_valid, one cycle  | o_status, o_match_count,
//           |           |                     | o_read_value, o_fill
//
// Append, read, errors, unused codes and any walk of an empty table go from the accept straight to the report.
// Count and both erase commands walk the fill through one memory read port.
// Insert-at shifts the entries from the index up one slot, then writes the new value at the index.
// busy is high from the accept until the cycle the result strobe shows; a new transaction
// may start in that strobe cycle. Synchronous active-low reset empties the table.
// The receiver cannot stall; each result is held for exactly one cycle.
module ordered_multiset_table_core
    import omt_pkg::*;
#(
    parameter int DEPTH = OMT_DEFAULT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_index,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [6:0]         o_match_count,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    logic signed [31:0]  r_val, n_val;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_wptr, n_wptr;
    logic                r_pend, n_pend;
    logic                r_hit, n_hit;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [1:0]          r_status, n_status;
    logic signed [31:0]  r_rdata;
    logic signed [31:0]  r_mem [DEPTH];

    logic                r_valid, n_valid;
    logic [1:0]          r_o_status, n_o_status;
    logic [6:0]          r_o_count, n_o_count;
    logic signed [31:0]  r_o_rdata, n_o_rdata;
    logic [6:0]          r_o_fill, n_o_fill;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic signed [31:0]  mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    logic                full;
    logic [IW-1:0]       idx_ext;
    logic [IW-1:0]       fill_ext;
    logic                data_eq;
    logic [CW-1:0]       fill_out;

    assign full     = (r_fill == CW'(DEPTH));
    assign idx_ext  = IW'(i_index);
    assign fill_ext = IW'(r_fill);
    assign data_eq  = (r_rdata == r_val);

    // Sequencer: decode in idle, walk the table one entry a cycle, then report.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_wptr     = r_wptr;
        n_pend     = r_pend;
        n_hit      = r_hit;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_valid    = 1'b0;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_rdata  = r_o_rdata;
        n_o_fill   = r_o_fill;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = r_val;
        mem_re     = 1'b0;
        mem_ra     = '0;
        fill_out   = r_fill;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_val    = i_value;
                    n_status = STATUS_OK;
                    n_cnt    = '0;
                    n_hit    = 1'b0;
                    n_ptr    = '0;
                    n_wptr   = '0;
                    n_pend   = 1'b0;
                    n_state  = ST_DONE;
                    case (i_cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = r_fill[AW-1:0];
                                mem_wd = i_value;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (full) begin
                                n_status = STATUS_FULL;
                            end else if (idx_ext > fill_ext) begin
                                n_status = STATUS_RANGE;
                            end else begin
                                n_idx   = CW'(i_index);
                                n_ptr   = r_fill;
                                n_state = ST_SHIFT;
                            end
                        end
                        CMD_COUNT, CMD_ERASE_ONE, CMD_ERASE_ALL: begin
                            if (r_fill != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_READ: begin
                            if (idx_ext >= fill_ext) begin
                                n_status = STATUS_RANGE;
                            end else begin
                                mem_re = 1'b1;
                                mem_ra = AW'(i_index);
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Issue the next read while the previous entry is compared.
                if (r_ptr != r_fill) begin
                    mem_re = 1'b1;
                    mem_ra = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_cmd == CMD_COUNT) begin
                        if (data_eq) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (data_eq && (r_cmd == CMD_ERASE_ALL || !r_hit)) begin
                        n_cnt = r_cnt + 1'b1;
                        n_hit = 1'b1;
                    end else begin
                        // Kept entries are packed down behind the read pointer.
                        mem_we = 1'b1;
                        mem_wa = r_wptr[AW-1:0];
                        mem_wd = r_rdata;
                        n_wptr = r_wptr + 1'b1;
                    end
                    if (r_ptr == r_fill) begin
                        n_state = ST_DONE;
                    end
                end
            end

            ST_SHIFT: begin
                // Read from the top down and write each entry one slot higher.
                if (r_ptr != r_idx) begin
                    mem_re = 1'b1;
                    mem_ra = AW'(r_ptr - 1'b1);
                    n_ptr  = r_ptr - 1'b1;
                    n_wptr = r_ptr;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wptr[AW-1:0];
                    mem_wd = r_rdata;
                end else if (r_ptr == r_idx) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_idx[AW-1:0];
                    mem_wd  = r_val;
                    n_fill  = r_fill + 1'b1;
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (r_cmd inside {CMD_ERASE_ONE, CMD_ERASE_ALL}) begin
                    fill_out   = r_wptr;
                    n_o_status = (r_cnt == '0) ? STATUS_NOT_FOUND : STATUS_OK;
                end else begin
                    n_o_status = r_status;
                end
                n_fill    = fill_out;
                n_o_fill  = 7'(fill_out);
                n_o_count = 7'(r_cnt);
                n_o_rdata = (r_cmd == CMD_READ && r_status == STATUS_OK) ? r_rdata : '0;
                n_valid   = 1'b1;
                n_state   = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_wptr     <= n_wptr;
        r_hit      <= n_hit;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_rdata  <= n_o_rdata;
        r_o_fill   <= n_o_fill;
    end

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_o_status;
    assign o_match_count = r_o_count;
    assign o_read_value  = r_o_rdata;
    assign o_fill        = r_o_fill;

endmodule

// File: design/omt_checker.sv
`include "ordered_multiset_table_core_macros.svh"

module omt_checker
    import omt_pkg::*;
#(
    parameter int DEPTH = OMT_DEFAULT_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_read_value,
    input logic [6:0]         o_fill
);

    // An accepted transaction keeps the core busy in the following cycle.
    `OMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")

    // A result appears only as the core returns to idle, after a busy cycle.
    `OMT_ASSERT_NOW(a_result_idle, o_valid, !busy && $past(busy), "result outside handoff")

    // A failed transaction never carries read data.
    `OMT_ASSERT_NOW(a_read_zero, o_valid && o_status != STATUS_OK, o_read_value == 0,
        "read data on an error result")

    // A full report means the table really holds every slot.
    `OMT_ASSERT_NOW(a_full_fill, o_valid && o_status == STATUS_FULL, o_fill == 7'(DEPTH),
        "full status with a partial fill")

endmodule

bind ordered_multiset_table_core omt_checker #(.DEPTH(DEPTH)) u_omt_checker (.*);
